>>> design/tbq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-axis biquad low-pass block.
// No dependencies; every other file imports this package.
package tbq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int STAMP_W    = 64;
    localparam int DELAY_W    = 20;
    localparam int STATE_W    = 40;
    localparam int STATE_FRAC = 8;
    localparam int FIELD_AXES = 3;
    localparam int AXIS_W     = 2;
    localparam int OPA_W      = 30;
    localparam int OPB_W      = 25;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 72;
    localparam int Y_W        = 48;
    localparam int Y_SPLIT    = 24;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    typedef enum logic [2:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_A1    = 3'd3,
        REG_A2    = 3'd4,
        REG_EN    = 3'd5,
        REG_DELAY = 3'd6
    } reg_idx_t;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_SEED   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        TERM_B0X,
        TERM_B1X,
        TERM_B2X,
        TERM_A1Y,
        TERM_A2Y,
        TERM_SEED1,
        TERM_SEED2
    } term_t;

    typedef struct packed {
        logic              valid;
        term_t             term;
        logic              hi;
        logic              last;
        logic [AXIS_W-1:0] axis;
    } mac_tag_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic                     enable;
        logic [DELAY_W-1:0]       delay_us;
    } cfg_t;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic [STAMP_W-1:0]         stamp_in;
    } in_item_t;

    typedef struct packed {
        logic                       status;
        logic signed [SAMPLE_W-1:0] filtered_x;
        logic signed [SAMPLE_W-1:0] filtered_y;
        logic signed [SAMPLE_W-1:0] filtered_z;
        logic [STAMP_W-1:0]         stamp_out;
    } out_item_t;

endpackage

>>> design/tbq_regs.sv
`timescale 1ns / 1ps
// APB-style register bank: coefficients, enable and group delay.
// Depends on tbq_pkg.
module tbq_regs import tbq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_B0:    cfg_reg.b0       <= pwdata[COEF_W-1:0];
                REG_B1:    cfg_reg.b1       <= pwdata[COEF_W-1:0];
                REG_B2:    cfg_reg.b2       <= pwdata[COEF_W-1:0];
                REG_A1:    cfg_reg.a1       <= pwdata[COEF_W-1:0];
                REG_A2:    cfg_reg.a2       <= pwdata[COEF_W-1:0];
                REG_EN:    cfg_reg.enable   <= pwdata[0];
                REG_DELAY: cfg_reg.delay_us <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_B0:    prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.b0};
            REG_B1:    prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.b1};
            REG_B2:    prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.b2};
            REG_A1:    prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.a1};
            REG_A2:    prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.a2};
            REG_EN:    prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.enable};
            REG_DELAY: prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg_reg.delay_us};
            default:   prdata = '0;
        endcase
    end

endmodule

>>> design/tbq_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product, then accumulator with
// rounding bias; gives each finished term rounded half up. Depends on tbq_pkg.
module tbq_mac import tbq_pkg::*; #(
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic signed [OPA_W-1:0] op_a,
    input  logic signed [OPB_W-1:0] op_b,
    input  mac_tag_t                tag_in,
    output logic signed [ACC_W-1:0] term,
    output mac_tag_t                tag_out
);

    localparam int X_SHIFT = COEF_FRAC_BITS - STATE_FRAC;
    localparam logic signed [ACC_W-1:0] X_BIAS = ACC_W'(1) <<< (X_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] Y_BIAS = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  bias;
    mac_tag_t                 tag1_reg;
    mac_tag_t                 tag2_reg;

    function automatic logic is_y_term(input term_t t);
        return (t == TERM_A1Y) || (t == TERM_A2Y);
    endfunction

    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        bias     = is_y_term(tag1_reg.term) ? Y_BIAS : X_BIAS;
        // upper partial of a split operand lands 24 bits up
        acc_next = tag1_reg.hi ? acc_reg + (prod_ext <<< Y_SPLIT) : bias + prod_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
        prod_reg <= op_a * op_b;
        if (tag1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign term    = is_y_term(tag2_reg.term) ? (acc_reg >>> COEF_FRAC_BITS)
                                              : (acc_reg >>> X_SHIFT);
    assign tag_out = tag2_reg;

endmodule

>>> design/three_axis_biquad_lowpass_top.sv
`timescale 1ns / 1ps
// Three-axis biquad low-pass, transposed direct form II, one shared multiplier.
// Per axis, of min(AXES,3): an enabled filter beat issues b0*x, b1*x, b2*x,
// then a1*y and a2*y as low and high partials; a seed beat issues both seed
// terms; if disabled, clamped samples pass. A new beat is taken in the cycle
// after handover to the output register; the multiplier issuing one partial
// product a cycle sets the rate. Reset clears registers, delay terms, handshake.
module three_axis_biquad_lowpass_top import tbq_pkg::*; #(
    parameter int AXES           = 3,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int USED_AXES = (AXES < FIELD_AXES) ? AXES : FIELD_AXES;
    localparam int AX_IDX_W  = (USED_AXES > 1) ? $clog2(USED_AXES) : 1;
    localparam logic [2:0] LAST_FILTER_STEP = 3'd6;
    localparam logic [2:0] LAST_SEED_STEP   = 3'd1;
    localparam logic signed [ACC_W-1:0] SMAX =
        (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
    localparam logic signed [ACC_W-1:0] YMAX = SMAX <<< STATE_FRAC;
    localparam logic signed [ACC_W-1:0] YMIN = SMIN <<< STATE_FRAC;
    localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (STATE_FRAC - 1);
    localparam logic signed [ACC_W-1:0] STATE_MAX =
        (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] STATE_MIN = ~STATE_MAX;
    localparam logic signed [OPA_W-1:0] ONE_A = OPA_W'(1) <<< COEF_FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    cfg_t cfg;

    state_t            state_reg;
    logic [AXIS_W-1:0] axis_reg;
    logic [2:0]        step_reg;
    logic              drain_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    in_item_t                   in_reg;
    logic signed [SAMPLE_W-1:0] x_reg      [USED_AXES];
    logic signed [STATE_W-1:0]  first_reg  [USED_AXES];
    logic signed [STATE_W-1:0]  second_reg [USED_AXES];
    logic signed [SAMPLE_W-1:0] res_reg    [FIELD_AXES];
    logic signed [Y_W-1:0]      y_reg;
    logic signed [ACC_W-1:0]    f_reg;
    logic signed [ACC_W-1:0]    s_reg;
    logic signed [OPA_W-1:0]    seed1_reg;
    logic signed [OPA_W-1:0]    seed2_reg;
    logic [STAMP_W-1:0]         stamp_reg;
    logic                       flag_reg;

    logic signed [SAMPLE_W-1:0] sample_arr [FIELD_AXES];
    logic signed [ACC_W-1:0]    xs_w       [USED_AXES];
    logic signed [SAMPLE_W-1:0] xc_w       [FIELD_AXES];
    logic                       clamp_any;

    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [OPB_W-1:0] x_op;
    logic signed [OPB_W-1:0] ylo_op;
    logic signed [OPB_W-1:0] yhi_op;
    mac_tag_t                issue_tag;
    mac_tag_t                fin_tag;
    logic signed [ACC_W-1:0] term;
    logic                    is_seed;
    logic [2:0]              last_step;
    logic [AX_IDX_W-1:0]     ax_i;
    logic [AX_IDX_W-1:0]     fa;
    logic                    fin;
    logic signed [ACC_W-1:0] ysum;
    logic signed [ACC_W-1:0] ysat;
    logic                    y_hit;
    logic signed [ACC_W-1:0] yround;
    logic signed [ACC_W-1:0] fsum;
    logic signed [ACC_W-1:0] fdiff;
    logic signed [ACC_W-1:0] sdiff;

    function automatic logic signed [STATE_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
        if (v > STATE_MAX) begin
            return STATE_MAX[STATE_W-1:0];
        end else if (v < STATE_MIN) begin
            return STATE_MIN[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    function automatic logic st_over(input logic signed [ACC_W-1:0] v);
        return (v > STATE_MAX) || (v < STATE_MIN);
    endfunction

    tbq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbq_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_a    (op_a),
        .op_b    (op_b),
        .tag_in  (issue_tag),
        .term    (term),
        .tag_out (fin_tag)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sample_arr[0] = in_reg.sample_x;
    assign sample_arr[1] = in_reg.sample_y;
    assign sample_arr[2] = in_reg.sample_z;

    assign is_seed   = (in_reg.operation == OP_SEED);
    assign last_step = is_seed ? LAST_SEED_STEP : LAST_FILTER_STEP;

    // clamp each sample to the configured sample range; axes not carried read 0
    always_comb begin
        clamp_any = 1'b0;
        for (int i = 0; i < FIELD_AXES; i++) begin
            xc_w[i] = '0;
        end
        for (int i = 0; i < USED_AXES; i++) begin
            xs_w[i] = ACC_W'(sample_arr[i]);
            if (xs_w[i] > SMAX) begin
                xc_w[i]   = SMAX[SAMPLE_W-1:0];
                clamp_any = 1'b1;
            end else if (xs_w[i] < SMIN) begin
                xc_w[i]   = SMIN[SAMPLE_W-1:0];
                clamp_any = 1'b1;
            end else begin
                xc_w[i] = sample_arr[i];
            end
        end
    end

    // operand selection for the step being issued
    always_comb begin
        ax_i   = axis_reg[AX_IDX_W-1:0];
        x_op   = OPB_W'(x_reg[ax_i]);
        ylo_op = {1'b0, y_reg[Y_SPLIT-1:0]};
        yhi_op = OPB_W'($signed(y_reg[Y_W-1:Y_SPLIT]));
        op_a   = OPA_W'(cfg.b0);
        op_b   = x_op;
        issue_tag       = '0;
        issue_tag.valid = (state_reg == ST_ISSUE);
        issue_tag.axis  = axis_reg;
        issue_tag.last  = 1'b1;
        issue_tag.term  = TERM_B0X;
        if (is_seed) begin
            if (step_reg == 3'd0) begin
                op_a           = seed1_reg;
                issue_tag.term = TERM_SEED1;
            end else begin
                op_a           = seed2_reg;
                issue_tag.term = TERM_SEED2;
            end
        end else begin
            case (step_reg)
                3'd0: begin
                    op_a           = OPA_W'(cfg.b0);
                    issue_tag.term = TERM_B0X;
                end
                3'd1: begin
                    op_a           = OPA_W'(cfg.b1);
                    issue_tag.term = TERM_B1X;
                end
                3'd2: begin
                    op_a           = OPA_W'(cfg.b2);
                    issue_tag.term = TERM_B2X;
                end
                3'd3: begin
                    op_a           = OPA_W'(cfg.a1);
                    op_b           = ylo_op;
                    issue_tag.term = TERM_A1Y;
                    issue_tag.last = 1'b0;
                end
                3'd4: begin
                    op_a           = OPA_W'(cfg.a1);
                    op_b           = yhi_op;
                    issue_tag.term = TERM_A1Y;
                    issue_tag.hi   = 1'b1;
                end
                3'd5: begin
                    op_a           = OPA_W'(cfg.a2);
                    op_b           = ylo_op;
                    issue_tag.term = TERM_A2Y;
                    issue_tag.last = 1'b0;
                end
                default: begin
                    op_a           = OPA_W'(cfg.a2);
                    op_b           = yhi_op;
                    issue_tag.term = TERM_A2Y;
                    issue_tag.hi   = 1'b1;
                end
            endcase
        end
    end

    // combine a finished term with the delay terms
    always_comb begin
        fin  = fin_tag.valid && fin_tag.last;
        fa   = fin_tag.axis[AX_IDX_W-1:0];
        ysum = term + ACC_W'(first_reg[fa]);
        y_hit = 1'b0;
        if (ysum > YMAX) begin
            ysat  = YMAX;
            y_hit = 1'b1;
        end else if (ysum < YMIN) begin
            ysat  = YMIN;
            y_hit = 1'b1;
        end else begin
            ysat = ysum;
        end
        yround = (ysat + Y_HALF) >>> STATE_FRAC;
        fsum   = term + ACC_W'(second_reg[fa]);
        fdiff  = f_reg - term;
        sdiff  = s_reg - term;
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            step_reg    <= '0;
            drain_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    axis_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= cfg.enable ? ST_ISSUE : ST_DONE;
                end
                ST_ISSUE: begin
                    if (step_reg == last_step) begin
                        step_reg <= '0;
                        if (axis_reg == AXIS_W'(USED_AXES - 1)) begin
                            drain_reg <= 1'b0;
                            state_reg <= ST_DRAIN;
                        end else begin
                            axis_reg <= axis_reg + AXIS_W'(1);
                        end
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.status     <= flag_reg;
                        m_data_reg.filtered_x <= res_reg[0];
                        m_data_reg.filtered_y <= res_reg[1];
                        m_data_reg.filtered_z <= res_reg[2];
                        m_data_reg.stamp_out  <= stamp_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_LOAD) begin
            flag_reg  <= clamp_any;
            seed1_reg <= ONE_A - OPA_W'(cfg.b0);
            seed2_reg <= OPA_W'(cfg.b2) - OPA_W'(cfg.a2);
            stamp_reg <= (in_reg.stamp_in <= STAMP_W'(cfg.delay_us))
                         ? STAMP_W'(1) : in_reg.stamp_in - STAMP_W'(cfg.delay_us);
            for (int i = 0; i < FIELD_AXES; i++) begin
                res_reg[i] <= xc_w[i];
            end
            for (int i = 0; i < USED_AXES; i++) begin
                x_reg[i] <= xc_w[i];
            end
        end
        if (fin) begin
            case (fin_tag.term)
                TERM_B0X: begin
                    y_reg                 <= ysat[Y_W-1:0];
                    res_reg[fin_tag.axis] <= yround[SAMPLE_W-1:0];
                    if (y_hit) begin
                        flag_reg <= 1'b1;
                    end
                end
                TERM_B1X: f_reg <= fsum;
                TERM_B2X: s_reg <= term;
                TERM_A1Y, TERM_A2Y, TERM_SEED1, TERM_SEED2: begin
                    if ((fin_tag.term == TERM_A1Y && st_over(fdiff))
                        || (fin_tag.term == TERM_A2Y && st_over(sdiff))
                        || (fin_tag.term != TERM_A1Y && fin_tag.term != TERM_A2Y
                            && st_over(term))) begin
                        flag_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // delay terms: cleared by reset and by a seed beat, written as terms finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < USED_AXES; i++) begin
                first_reg[i]  <= '0;
                second_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_LOAD && is_seed) begin
                for (int i = 0; i < USED_AXES; i++) begin
                    first_reg[i]  <= '0;
                    second_reg[i] <= '0;
                end
            end
            if (fin) begin
                case (fin_tag.term)
                    TERM_A1Y:   first_reg[fa]  <= sat_st(fdiff);
                    TERM_A2Y:   second_reg[fa] <= sat_st(sdiff);
                    TERM_SEED1: first_reg[fa]  <= sat_st(term);
                    TERM_SEED2: second_reg[fa] <= sat_st(term);
                    default: ;
                endcase
            end
        end
    end

    // pipeline is empty whenever a new beat can be taken
    a_drained_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !fin_tag.valid)
        else $error("multiplier pipeline busy while accepting a beat");

    // a seed beat never issues feedback terms
    a_seed_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue_tag.valid && is_seed)
        |-> (issue_tag.term == TERM_SEED1 || issue_tag.term == TERM_SEED2))
        else $error("feedback term issued for a seed beat");

    // handing over from the sequencer always raises the result valid
    a_done_hands_over: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished result not presented");

endmodule
